// ----- hw/rtl/rmap_pkg.sv -----
// ----------------------------------------------------------------------------
// RMAP parser package
// Shared types, constants and the CRC-8 step used by the parser.
// ----------------------------------------------------------------------------
package rmap_pkg;

  typedef enum logic [1:0] {
    KIND_PATH    = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_NO_LA    = 3'd2,
    ERR_PROTOCOL = 3'd3,
    ERR_HDR_CRC  = 3'd4,
    ERR_LENGTH   = 3'd5,
    ERR_DATA_CRC = 3'd6
  } err_e;

  typedef enum logic [1:0] {
    PH_PATH   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  localparam int unsigned CfgIdxHdrCrc  = 0;
  localparam int unsigned CfgIdxDataCrc = 1;

  localparam logic [7:0] ProtocolId = 8'h01;
  localparam logic [7:0] PathLimit  = 8'h20;

  // Result queue entries; power of two, at least 4 (two writes a cycle)
  localparam int unsigned QueueDepth = 4;

  // One result item, passed from the parser to the output queue.
  typedef struct packed {
    kind_e        kind;
    logic [7:0]   out_byte;
    logic         packet_done;
    logic [7:0]   instruction;
    logic [7:0]   key_or_status;
    logic [7:0]   target_logical_address;
    logic [7:0]   initiator_logical_address;
    logic [15:0]  transaction_id;
    logic [7:0]   extended_address;
    logic [31:0]  memory_address;
    logic [23:0]  data_length;
    err_e         error_code;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

  // Reflected CRC-8, poly x^8+x^2+x+1 (0xE0 reflected).
  function automatic logic [7:0] crc8_step(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 8'hE0) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/rmap_if.sv -----
// ----------------------------------------------------------------------------
// RMAP stream interfaces
// Valid/ready channels for the byte input and the result output.
// ----------------------------------------------------------------------------
interface rmap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_packet;
  modport source (output valid, byte_value, end_of_packet, input ready);
  modport sink   (input valid, byte_value, end_of_packet, output ready);
endinterface

interface rmap_out_if;
  logic         valid;
  logic         ready;
  logic [1:0]   kind;
  logic [7:0]   out_byte;
  logic         packet_done;
  logic [7:0]   instruction;
  logic [7:0]   key_or_status;
  logic [7:0]   target_logical_address;
  logic [7:0]   initiator_logical_address;
  logic [15:0]  transaction_id;
  logic [7:0]   extended_address;
  logic [31:0]  memory_address;
  logic [23:0]  data_length;
  logic [2:0]   error_code;
  modport source (output valid, kind, out_byte, packet_done, instruction, key_or_status,
                  target_logical_address, initiator_logical_address, transaction_id,
                  extended_address, memory_address, data_length, error_code,
                  input ready);
  modport sink   (input valid, kind, out_byte, packet_done, instruction, key_or_status,
                  target_logical_address, initiator_logical_address, transaction_id,
                  extended_address, memory_address, data_length, error_code,
                  output ready);
endinterface

// ----- hw/rtl/rmap_packet_parser_checker_core.sv -----
// ----------------------------------------------------------------------------
// RMAP packet parser and checker
// Decodes an RMAP byte stream into path, reply-address, data and summary
// results, checking protocol id, lengths and header/data CRC-8.
// ----------------------------------------------------------------------------
// One input byte is accepted every clock cycle while the result queue has room
// for two entries; each byte produces zero, one or two results (a passed byte
// and/or the packet summary). Results of a byte are written to the queue
// registers and reach the output behind any older queued results. The output side
// delivers one result per cycle while out_if.ready is high, so the sustained rate
// is one byte per cycle except where the output stalls or a byte produces two
// results, whose second result must also be drained from the queue.
module rmap_packet_parser_checker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmap_in_if.sink    in_if,
  rmap_out_if.source out_if,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_wdata_i
);
  import rmap_pkg::*;

  logic    chk_hdr_q, chk_data_q;
  logic    accept, space2;
  logic    r0v, r1v;
  result_t r0, r1, rd;

  // config registers; index wider than the list is unneeded with one bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_hdr_q  <= 1'b1;
      chk_data_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'(CfgIdxHdrCrc)) chk_hdr_q <= cfg_wdata_i;
      else chk_data_q <= cfg_wdata_i;
    end
  end

  assign in_if.ready = space2;
  assign accept      = in_if.valid & space2;

  rmap_parser u_parser (
    .clk_i,
    .rst_ni,
    .in_valid_i   (accept),
    .in_byte_i    (in_if.byte_value),
    .in_eop_i     (in_if.end_of_packet),
    .chk_hdr_i    (chk_hdr_q),
    .chk_data_i   (chk_data_q),
    .res0_valid_o (r0v),
    .res0_o       (r0),
    .res1_valid_o (r1v),
    .res1_o       (r1)
  );

  rmap_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .wr0_i    (r0v),
    .wd0_i    (r0),
    .wr1_i    (r1v),
    .wd1_i    (r1),
    .space2_o (space2),
    .valid_o  (out_if.valid),
    .ready_i  (out_if.ready),
    .rd_o     (rd)
  );

  assign out_if.kind                      = rd.kind;
  assign out_if.out_byte                  = rd.out_byte;
  assign out_if.packet_done               = rd.packet_done;
  assign out_if.instruction               = rd.instruction;
  assign out_if.key_or_status             = rd.key_or_status;
  assign out_if.target_logical_address    = rd.target_logical_address;
  assign out_if.initiator_logical_address = rd.initiator_logical_address;
  assign out_if.transaction_id            = rd.transaction_id;
  assign out_if.extended_address          = rd.extended_address;
  assign out_if.memory_address            = rd.memory_address;
  assign out_if.data_length               = rd.data_length;
  assign out_if.error_code                = rd.error_code;

  // a waiting result stays put until its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(rd)))
    else $error("waiting result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.packet_done) |-> (out_if.kind == KIND_SUMMARY))
    else $error("summary flag on non-summary");
  assert property (@(posedge clk_i) disable iff (!rst_ni) r0v |-> accept)
    else $error("result without accepted byte");

endmodule

// ----- hw/rtl/rmap_parser.sv -----
// ----------------------------------------------------------------------------
// RMAP parser front end
// Classifies each byte, tracks header fields and CRCs, and produces up to
// two result items per byte.
// ----------------------------------------------------------------------------
module rmap_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_eop_i,
  input  logic                chk_hdr_i,
  input  logic                chk_data_i,
  output logic                res0_valid_o,
  output rmap_pkg::result_t   res0_o,
  output logic                res1_valid_o,
  output rmap_pkg::result_t   res1_o
);
  import rmap_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [7:0]  hcrc_q, hcrc_d, dcrc_q, dcrc_d;
  logic [23:0] rem_q, rem_d;
  logic [63:0] f0_q, f0_d, f1_q, f1_d;
  err_e        err_q, err_d;

  logic [7:0] b;
  logic [7:0] instr;
  logic       cmd, wr, crc_byte, has_data, clr;
  logic [4:0] base, q;
  logic       emit_b, emit_s;
  kind_e      bkind;
  err_e       scode;

  assign b     = in_byte_i;
  assign instr = f0_q[7:0];
  assign cmd   = instr[6];
  assign wr    = instr[5];
  assign base  = 5'd4 + {1'b0, instr[1:0], 2'b00};
  assign q     = pos_q - base;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    hcrc_d   = hcrc_q;
    dcrc_d   = dcrc_q;
    rem_d    = rem_q;
    f0_d     = f0_q;
    f1_d     = f1_q;
    err_d    = err_q;
    emit_b   = 1'b0;
    emit_s   = 1'b0;
    bkind    = KIND_PATH;
    scode    = ERR_OK;
    crc_byte = 1'b0;
    has_data = 1'b0;
    if (in_valid_i) begin
      unique case (phase_q) inside
        PH_PATH, PH_HEADER: begin
          if (phase_q == PH_PATH && b < PathLimit) begin
            emit_b = 1'b1;
            if (in_eop_i) begin
              emit_s = 1'b1;
              scode  = ERR_NO_LA;
            end
          end else begin
            // header byte; at the first header byte position is zero
            if (phase_q == PH_PATH) phase_d = PH_HEADER;
            if (pos_q == 5'd0 || phase_q == PH_PATH) begin
              f0_d[23:16] = b;
            end else if (pos_q == 5'd1) begin
              if (b != ProtocolId) err_d = ERR_PROTOCOL;
            end else if (pos_q == 5'd2) begin
              f0_d[7:0] = b;
              if (!b[6]) begin
                f0_d[31:24] = f0_q[23:16];
                f0_d[23:16] = 8'd0;
              end
            end else if (pos_q == 5'd3) begin
              f0_d[15:8] = b;
            end else if (cmd) begin
              if (pos_q < base) begin
                emit_b = 1'b1;
                bkind  = KIND_REPLY;
              end else if (q == 5'd0) f0_d[31:24] = b;
              else if (q <= 5'd2) f0_d[47:32] = {f0_q[39:32], b};
              else if (q == 5'd3) f0_d[55:48] = b;
              else if (q <= 5'd7) f1_d[31:0] = {f1_q[23:0], b};
              else if (q <= 5'd10) f1_d[55:32] = {f1_q[47:32], b};
              else crc_byte = 1'b1;
            end else begin
              if (pos_q == 5'd4) f0_d[23:16] = b;
              else if (pos_q <= 5'd6) f0_d[47:32] = {f0_q[39:32], b};
              else if (pos_q == 5'd7) crc_byte = wr;
              else if (pos_q <= 5'd10) f1_d[55:32] = {f1_q[47:32], b};
              else crc_byte = 1'b1;
            end
            // reply address bytes are suppressed after a bad protocol id
            if (err_d == ERR_PROTOCOL) begin
              emit_b = 1'b0;
              if (in_eop_i) begin
                emit_s = 1'b1;
                scode  = ERR_SHORT;
              end else begin
                phase_d = PH_SKIP;
                pos_d   = (phase_q == PH_PATH) ? 5'd1 : pos_q + 5'd1;
              end
            end else if (!crc_byte) begin
              hcrc_d = crc8_step(hcrc_q, b);
              if (in_eop_i) begin
                emit_s = 1'b1;
                scode  = ERR_SHORT;
              end else begin
                pos_d = (phase_q == PH_PATH) ? 5'd1 : pos_q + 5'd1;
              end
            end else begin
              has_data = cmd ? wr : !wr;
              if (chk_hdr_i && hcrc_q != b) err_d = ERR_HDR_CRC;
              if (in_eop_i) begin
                emit_s = 1'b1;
                scode  = (err_d != ERR_OK) ? err_d : (has_data ? ERR_LENGTH : ERR_OK);
              end else if (err_d != ERR_OK || !has_data) begin
                phase_d = PH_SKIP;
              end else begin
                phase_d = PH_DATA;
                rem_d   = f1_q[55:32];
              end
            end
          end
        end
        PH_DATA: begin
          if (rem_q != 24'd0) begin
            if (in_eop_i) begin
              emit_s = 1'b1;
              scode  = ERR_LENGTH;
            end else begin
              emit_b = 1'b1;
              bkind  = KIND_DATA;
              dcrc_d = crc8_step(dcrc_q, b);
              rem_d  = rem_q - 24'd1;
            end
          end else if (in_eop_i) begin
            emit_s = 1'b1;
            scode  = (chk_data_i && dcrc_q != b) ? ERR_DATA_CRC : ERR_OK;
          end else begin
            err_d   = ERR_LENGTH;
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (in_eop_i) begin
            emit_s = 1'b1;
            scode  = (err_q == ERR_PROTOCOL && pos_q < 5'd7) ? ERR_SHORT : err_q;
          end else if (pos_q != 5'd31) begin
            pos_d = pos_q + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign clr = emit_s;

  // byte result, then summary; summary sits in slot 0 if no byte precedes it
  result_t rb, rs;
  always_comb begin
    rb = '0;
    rb.kind     = bkind;
    rb.out_byte = b;
    rs = '0;
    rs.kind                      = KIND_SUMMARY;
    rs.packet_done               = 1'b1;
    rs.instruction               = f0_d[7:0];
    rs.key_or_status             = f0_d[15:8];
    rs.target_logical_address    = f0_d[23:16];
    rs.initiator_logical_address = f0_d[31:24];
    rs.transaction_id            = f0_d[47:32];
    rs.extended_address          = f0_d[55:48];
    rs.memory_address            = f1_d[31:0];
    rs.data_length               = f1_d[55:32];
    rs.error_code                = scode;
  end

  assign res0_valid_o = emit_b | emit_s;
  assign res0_o       = emit_b ? rb : rs;
  assign res1_valid_o = emit_b & emit_s;
  assign res1_o       = rs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PATH;
      pos_q   <= '0;
      hcrc_q  <= '0;
      dcrc_q  <= '0;
      rem_q   <= '0;
      f0_q    <= '0;
      f1_q    <= '0;
      err_q   <= ERR_OK;
    end else if (clr) begin
      phase_q <= PH_PATH;
      pos_q   <= '0;
      hcrc_q  <= '0;
      dcrc_q  <= '0;
      rem_q   <= '0;
      f0_q    <= '0;
      f1_q    <= '0;
      err_q   <= ERR_OK;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      hcrc_q  <= hcrc_d;
      dcrc_q  <= dcrc_d;
      rem_q   <= rem_d;
      f0_q    <= f0_d;
      f1_q    <= f1_d;
      err_q   <= err_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) res1_valid_o |-> res0_valid_o)
    else $error("second result without first");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res1_valid_o |-> (res1_o.kind == KIND_SUMMARY && res0_o.kind != KIND_SUMMARY))
    else $error("bad result pair order");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (err_q == ERR_OK))
    else $error("data phase with latched error");

endmodule

// ----- hw/rtl/rmap_fifo.sv -----
// ----------------------------------------------------------------------------
// RMAP result queue
// Small queue that takes up to two results a cycle and delivers one.
// ----------------------------------------------------------------------------
module rmap_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr0_i,
  input  rmap_pkg::result_t wd0_i,
  input  logic              wr1_i,
  input  rmap_pkg::result_t wd1_i,
  output logic              space2_o,
  output logic              valid_o,
  input  logic              ready_i,
  output rmap_pkg::result_t rd_o
);
  import rmap_pkg::*;

  localparam int unsigned Depth = QueueDepth;
  localparam int unsigned AW    = $clog2(Depth);

  result_t          mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             pop;
  logic [AW:0]      nwr;

  assign valid_o  = cnt_q != '0;
  assign rd_o     = mem_q[rp_q];
  assign pop      = valid_o & ready_i;
  assign nwr      = {{AW{1'b0}}, wr0_i} + {{AW{1'b0}}, wr1_i};
  assign space2_o = cnt_q <= (AW+1)'(Depth - 2);

  always_ff @(posedge clk_i) begin
    if (wr0_i) mem_q[wp_q] <= wd0_i;
    if (wr1_i) mem_q[wp_q + AW'(1)] <= wd1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + nwr[AW-1:0];
      if (pop) rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + nwr - {{AW{1'b0}}, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (AW+1)'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr1_i |-> wr0_i)
    else $error("write lane 1 without lane 0");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |=> (cnt_q <= 2))
    else $error("queue grew too fast");

endmodule
